/* src/slte_pkg.sv */
// ============================================================================
// slte_pkg
// Shared constants, codes and controller/datapath interface types for the
// sorted linked table engine.
// ============================================================================
`default_nettype none

package slte_pkg;

  localparam int ENTRIES  = 64;
  localparam int KEY_BITS = 32;

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int LINK_W = $clog2(ENTRIES + 1);
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(ENTRIES);

  // Input item: command, key
  localparam int IN_BITS = 2 + KEY_BITS;
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

  // Result item: success, slot, status, entry_count
  localparam int OUT_SLOT_LSB  = 1;
  localparam int OUT_STAT_LSB  = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_CNT_LSB   = OUT_STAT_LSB + 2;
  localparam int OUT_BITS      = OUT_CNT_LSB + CNT_W;
  localparam int OUT_W         = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK,
    S_POST,
    S_INS_READ,
    S_INS_LINK,
    S_INS_PREV,
    S_DEL_UNLINK,
    S_DEL_FREE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    load_item;
    logic    walk_start;
    logic    walk_step;
    logic    ins_read;
    logic    ins_link;
    logic    ins_prev;
    logic    del_unlink;
    logic    del_free;
    logic    clear;
    logic    out_load;
    logic    res_ok;
    status_t res_status;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e_t cmd;
    logic   free_empty;
    logic   head_null;
    logic   walk_done;
    logic   found;
    logic   out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/slte_ram.sv */
// ============================================================================
// slte_ram
// Generic single-write, single-read memory with registered read data.
// ============================================================================
`default_nettype none

module slte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/slte_ctrl.sv */
// ============================================================================
// slte_ctrl
// Command sequencer: accepts an item, runs the list walk and the link
// updates of the command, then hands the result to the output register.
// ============================================================================
`default_nettype none

module slte_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  slte_pkg::dp_stat_t stat,
  output slte_pkg::dp_cmd_t  cmd
);

  import slte_pkg::*;

  state_t  state, state_next;
  logic    res_ok, res_ok_next;
  status_t res_status, res_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    res_ok     <= res_ok_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next      = state;
    res_ok_next     = res_ok;
    res_status_next = res_status;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.cmd == CMD_CLEAR) begin
          res_ok_next     = 1'b1;
          res_status_next = ST_OK;
          state_next      = S_FINISH;
        end else if (stat.cmd == CMD_INSERT && stat.free_empty) begin
          res_ok_next     = 1'b0;
          res_status_next = ST_FULL;
          state_next      = S_FINISH;
        end else if (stat.head_null) begin
          state_next = S_POST;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.walk_done) state_next = S_POST;
      end
      S_POST: begin
        case (stat.cmd)
          CMD_INSERT: begin
            if (stat.found) begin
              res_ok_next     = 1'b0;
              res_status_next = ST_DUPLICATE;
              state_next      = S_FINISH;
            end else begin
              state_next = S_INS_READ;
            end
          end
          CMD_DELETE: begin
            if (stat.found) begin
              state_next = S_DEL_UNLINK;
            end else begin
              res_ok_next     = 1'b0;
              res_status_next = ST_NOT_FOUND;
              state_next      = S_FINISH;
            end
          end
          default: begin
            res_ok_next     = stat.found;
            res_status_next = stat.found ? ST_OK : ST_NOT_FOUND;
            state_next      = S_FINISH;
          end
        endcase
      end
      S_INS_READ:   state_next = S_INS_LINK;
      S_INS_LINK:   state_next = S_INS_PREV;
      S_INS_PREV: begin
        res_ok_next     = 1'b1;
        res_status_next = ST_OK;
        state_next      = S_FINISH;
      end
      S_DEL_UNLINK: state_next = S_DEL_FREE;
      S_DEL_FREE: begin
        res_ok_next     = 1'b1;
        res_status_next = ST_OK;
        state_next      = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.res_ok     = res_ok;
    cmd.res_status = res_status;
    s_tready       = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready      = 1'b1;
        cmd.load_item = s_tvalid;
      end
      S_DISPATCH: begin
        cmd.clear      = (stat.cmd == CMD_CLEAR);
        cmd.walk_start = (stat.cmd != CMD_CLEAR) &&
                         !(stat.cmd == CMD_INSERT && stat.free_empty);
      end
      S_WALK:       cmd.walk_step  = 1'b1;
      S_POST:       ;
      S_INS_READ:   cmd.ins_read   = 1'b1;
      S_INS_LINK:   cmd.ins_link   = 1'b1;
      S_INS_PREV:   cmd.ins_prev   = 1'b1;
      S_DEL_UNLINK: cmd.del_unlink = 1'b1;
      S_DEL_FREE:   cmd.del_free   = 1'b1;
      S_FINISH:     cmd.out_load   = !stat.out_busy;
      default:      ;
    endcase
  end

endmodule

`default_nettype wire

/* src/slte_dp.sv */
// ============================================================================
// slte_dp
// Datapath: key and link memories, list and free-chain heads, walk
// registers, element count and the result output register.
// ============================================================================
`default_nettype none

module slte_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  slte_pkg::dp_cmd_t            cmd,
  output slte_pkg::dp_stat_t           stat,
  input  logic [slte_pkg::IN_W-1:0]    s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [slte_pkg::OUT_W-1:0]   m_tdata
);

  import slte_pkg::*;

  cmd_e_t              cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [LINK_W-1:0]   head, free_head, cur, prev, nxt;
  logic [SLOT_W-1:0]   slot_q;
  logic                found;
  logic [CNT_W-1:0]    count;
  logic [ENTRIES-1:0]  lnk_vld;

  logic [SLOT_W-1:0]   rd_addr, rd_addr_q;
  logic [KEY_BITS-1:0] key_rd;
  logic [LINK_W-1:0]   lnk_raw, lnk_rd, next_lnk;
  logic                key_ge, key_eq;

  logic                lnk_we, key_we;
  logic [SLOT_W-1:0]   lnk_waddr;
  logic [LINK_W-1:0]   lnk_wdata;

  logic                out_ok;
  status_t             out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [CNT_W-1:0]    out_cnt;

  slte_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (slot_q),
    .wdata (key_q),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  slte_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (rd_addr),
    .rdata (lnk_raw)
  );

  // A link never written since reset or clear reads as its rebuilt value i+1
  assign lnk_rd   = lnk_vld[rd_addr_q] ? lnk_raw : LINK_W'(rd_addr_q) + LINK_W'(1);
  assign next_lnk = (lnk_rd >= LINK_NULL) ? LINK_NULL : lnk_rd;
  assign key_ge   = $signed(key_rd) >= $signed(key_q);
  assign key_eq   = key_rd == key_q;

  always_comb begin
    rd_addr = free_head[SLOT_W-1:0];
    if (cmd.walk_start) begin
      rd_addr = head[SLOT_W-1:0];
    end else if (cmd.walk_step) begin
      rd_addr = next_lnk[SLOT_W-1:0];
    end
  end

  always_comb begin
    key_we    = cmd.ins_link;
    lnk_we    = 1'b0;
    lnk_waddr = slot_q;
    lnk_wdata = cur;
    if (cmd.ins_link) begin
      lnk_we = 1'b1;
    end else if (cmd.ins_prev) begin
      lnk_we    = (prev != LINK_NULL);
      lnk_waddr = prev[SLOT_W-1:0];
      lnk_wdata = LINK_W'(slot_q);
    end else if (cmd.del_unlink) begin
      lnk_we    = (prev != LINK_NULL);
      lnk_waddr = prev[SLOT_W-1:0];
      lnk_wdata = nxt;
    end else if (cmd.del_free) begin
      lnk_we    = 1'b1;
      lnk_wdata = free_head;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= LINK_NULL;
      free_head <= '0;
      count     <= '0;
      lnk_vld   <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        head      <= LINK_NULL;
        free_head <= '0;
        count     <= '0;
        lnk_vld   <= '0;
      end else if (lnk_we) begin
        lnk_vld[lnk_waddr] <= 1'b1;
      end
      if (cmd.ins_link) free_head <= next_lnk;
      if (cmd.ins_prev) begin
        if (prev == LINK_NULL) head <= LINK_W'(slot_q);
        count <= count + CNT_W'(1);
      end
      if (cmd.del_unlink && prev == LINK_NULL) head <= nxt;
      if (cmd.del_free) begin
        free_head <= LINK_W'(slot_q);
        if (count != '0) count <= count - CNT_W'(1);
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    if (cmd.load_item) begin
      cmd_q <= cmd_e_t'(s_tdata[1:0]);
      key_q <= s_tdata[2 +: KEY_BITS];
    end
    if (cmd.walk_start) begin
      cur   <= head;
      prev  <= LINK_NULL;
      found <= 1'b0;
    end
    if (cmd.walk_step) begin
      if (key_ge) begin
        found  <= key_eq;
        nxt    <= next_lnk;
        slot_q <= cur[SLOT_W-1:0];
      end else begin
        prev <= cur;
        cur  <= next_lnk;
      end
    end
    if (cmd.ins_read) slot_q <= free_head[SLOT_W-1:0];
    if (cmd.out_load) begin
      out_ok     <= cmd.res_ok;
      out_status <= cmd.res_status;
      out_slot   <= (cmd.res_ok && cmd_q != CMD_CLEAR) ? slot_q : '0;
      out_cnt    <= count;
    end
  end

  assign stat.cmd        = cmd_q;
  assign stat.free_empty = (free_head == LINK_NULL);
  assign stat.head_null  = (head == LINK_NULL);
  assign stat.walk_done  = key_ge || (next_lnk == LINK_NULL);
  assign stat.found      = found;
  assign stat.out_busy   = m_tvalid && !m_tready;

  assign m_tdata = OUT_W'({out_cnt, out_status, out_slot, out_ok});

endmodule

`default_nettype wire

/* src/sorted_linked_table_engine_top.sv */
// ============================================================================
// sorted_linked_table_engine_top
// Sorted linked key table with a free chain of unused slots.
// ============================================================================
// Input channel s_*: one command item (insert, delete, search, clear) with a
// signed key. Output channel m_*: exactly one result item per command with
// success, slot, status and the element count after the command.
// Commands run one at a time. s_tready is high only while the sequencer is
// idle. The walk visits one list slot per cycle, at most 64 in all, through
// the registered read of the key and link memories. An insert that stores its
// key then takes the free-chain head, links it and updates its predecessor or
// the list head; a delete that frees a slot unlinks it and returns it to the
// free chain; clear and an insert into a full table skip the walk.
// The next item can be accepted in the cycle after its result is loaded.
// The result sits in an output register: a stalled receiver holds m_tdata
// and m_tvalid, and the sequencer waits in its last step only when a new
// result is ready while the old one is still not taken.
// Reset (rst, synchronous) empties the table and rebuilds the free chain at
// once through per-slot link valid bits; no clearing pass is needed.
// ============================================================================
`default_nettype none

module sorted_linked_table_engine_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [slte_pkg::IN_W-1:0]  s_tdata,   // command[1:0], key[33:2], zero pad
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [slte_pkg::OUT_W-1:0] m_tdata    // success, slot, status, entry_count
);

  import slte_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  slte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  slte_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

/* src/slte_checker.sv */
// ============================================================================
// slte_checker
// Port-level checks on the result channel of the sorted linked table engine.
// ============================================================================
`default_nettype none

module slte_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [slte_pkg::OUT_W-1:0] m_tdata
);

  import slte_pkg::*;

  logic                ok;
  logic [SLOT_W-1:0]   slot;
  logic [1:0]          status;
  logic [CNT_W-1:0]    cnt;

  assign ok     = m_tdata[0];
  assign slot   = m_tdata[OUT_STAT_LSB-1:OUT_SLOT_LSB];
  assign status = m_tdata[OUT_CNT_LSB-1:OUT_STAT_LSB];
  assign cnt    = m_tdata[OUT_BITS-1:OUT_CNT_LSB];

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !ok |-> slot == '0)
    else $error("failed command reports a slot");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (ok == (status == ST_OK)))
    else $error("success and status disagree");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> cnt <= CNT_W'(ENTRIES))
    else $error("element count above capacity");

endmodule

bind sorted_linked_table_engine_top slte_checker u_slte_checker (.*);

`default_nettype wire

/* dv/tb_sorted_linked_table_engine_top.sv */
// ============================================================================
// tb_sorted_linked_table_engine_top
// Self-checking bench for the sorted linked key table. A directed table covers
// empty-table misses, the key extremes, duplicates, deletes that feed the free
// chain and clear; random phases then fill the table to capacity, drain it and
// mix all commands. Every result is checked against its typed row where one
// is given, else against a local model of the table.
// ============================================================================
module tb_sorted_linked_table_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slte_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int STALL_PCT    = 27;
  localparam int WATCHDOG_MAX = 3000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic              success;
    logic [SLOT_W-1:0] slot;
    status_t           status;
    logic [CNT_W-1:0]  count;
  } table_result_t;

  typedef struct {
    cmd_e_t        cmd;
    logic [31:0]   key;
    bit            typed;
    table_result_t res;
  } stim_row_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  // Local copy of the table
  logic signed [KEY_BITS-1:0] mirror_key [ENTRIES];
  logic [LINK_W-1:0]          mirror_link[ENTRIES];
  logic [LINK_W-1:0]          mirror_head;
  logic [LINK_W-1:0]          mirror_free;
  logic [CNT_W-1:0]           mirror_count;

  table_result_t expected_results[$];
  stim_row_t     directed_rows[$];

  bit calm = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int n_insert = 0, n_delete = 0, n_search = 0, n_clear = 0;
  int n_full = 0, n_dup = 0, n_miss = 0, peak_count = 0;

  sorted_linked_table_engine_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // command[1:0], key[33:2], zero pad
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // success, slot[6:1], status[8:7], entry_count[15:9]
  );

  always #2 clk = ~clk;

  function automatic void rebuild_table();
    for (int i = 0; i < ENTRIES; i++)
      mirror_link[i] = (i + 1 < ENTRIES) ? LINK_W'(i + 1) : LINK_NULL;
    mirror_head  = LINK_NULL;
    mirror_free  = '0;
    mirror_count = '0;
  endfunction

  function automatic logic [LINK_W-1:0] next_link(logic [LINK_W-1:0] i);
    if (i >= ENTRIES) return LINK_NULL;
    return (mirror_link[i[SLOT_W-1:0]] < ENTRIES) ? mirror_link[i[SLOT_W-1:0]] : LINK_NULL;
  endfunction

  // First slot whose key is not below k; prev gets its predecessor.
  function automatic logic [LINK_W-1:0] locate(logic signed [KEY_BITS-1:0] k,
                                               output logic [LINK_W-1:0] prev);
    logic [LINK_W-1:0] i;
    int n;
    prev = LINK_NULL;
    i = (mirror_head < ENTRIES) ? mirror_head : LINK_NULL;
    for (n = 0; n < ENTRIES && i != LINK_NULL; n++) begin
      if (mirror_key[i[SLOT_W-1:0]] >= k) break;
      prev = i;
      i = next_link(i);
    end
    if (n >= ENTRIES) i = LINK_NULL;
    return i;
  endfunction

  function automatic table_result_t predict_command(cmd_e_t cmd, logic [31:0] raw_key);
    table_result_t r;
    logic signed [KEY_BITS-1:0] k;
    logic [LINK_W-1:0] prev, at, s;
    r = '0;
    k = raw_key;
    case (cmd)
      CMD_INSERT: begin
        if (mirror_free >= ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          at = locate(k, prev);
          if (at != LINK_NULL && mirror_key[at[SLOT_W-1:0]] == k) begin
            r.status = ST_DUPLICATE;
          end else begin
            s = mirror_free;
            mirror_free = next_link(s);
            mirror_key[s[SLOT_W-1:0]] = k;
            if (prev == LINK_NULL) begin
              mirror_link[s[SLOT_W-1:0]] = (mirror_head < ENTRIES) ? mirror_head : LINK_NULL;
              mirror_head = s;
            end else begin
              mirror_link[s[SLOT_W-1:0]] = next_link(prev);
              mirror_link[prev[SLOT_W-1:0]] = s;
            end
            mirror_count++;
            r.success = 1'b1;
            r.slot = s[SLOT_W-1:0];
          end
        end
      end
      CMD_DELETE: begin
        at = locate(k, prev);
        if (at == LINK_NULL || mirror_key[at[SLOT_W-1:0]] != k) begin
          r.status = ST_NOT_FOUND;
        end else begin
          if (prev == LINK_NULL) mirror_head = next_link(at);
          else mirror_link[prev[SLOT_W-1:0]] = next_link(at);
          mirror_link[at[SLOT_W-1:0]] = (mirror_free < ENTRIES) ? mirror_free : LINK_NULL;
          mirror_free = at;
          if (mirror_count > 0) mirror_count--;
          r.success = 1'b1;
          r.slot = at[SLOT_W-1:0];
        end
      end
      CMD_SEARCH: begin
        at = locate(k, prev);
        if (at != LINK_NULL && mirror_key[at[SLOT_W-1:0]] == k) begin
          r.success = 1'b1;
          r.slot = at[SLOT_W-1:0];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: begin
        rebuild_table();
        r.success = 1'b1;
      end
    endcase
    r.count = mirror_count;
    return r;
  endfunction

  // Any key currently linked, picked at random
  function automatic logic [31:0] pick_held_key();
    logic [LINK_W-1:0] i;
    int steps;
    if (mirror_count == 0) return $urandom;
    steps = $urandom_range(int'(mirror_count) - 1);
    i = mirror_head;
    repeat (steps) i = next_link(i);
    return mirror_key[i[SLOT_W-1:0]];
  endfunction

  function automatic logic [31:0] choose_key();
    int r;
    r = $urandom_range(9);
    if (r <= 4 && mirror_count > 0) return pick_held_key();
    if (r <= 6) return 32'($signed($urandom_range(16)) - 8);
    if (r == 7) begin
      case ($urandom_range(3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  task automatic add_row(cmd_e_t cmd, logic [31:0] key, bit typed, logic ok,
                         int slot, status_t st, int cnt);
    stim_row_t row;
    row.cmd = cmd;
    row.key = key;
    row.typed = typed;
    row.res = '{success: ok, slot: SLOT_W'(slot), status: st, count: CNT_W'(cnt)};
    directed_rows.push_back(row);
  endtask

  task automatic send_item(cmd_e_t cmd, logic [31:0] key, bit typed = 1'b0,
                           table_result_t typed_res = '0);
    table_result_t res;
    if (!calm) begin
      while ($urandom_range(99) < STALL_PCT) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - 2 - KEY_BITS){1'b0}}, key, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = predict_command(cmd, key);
    if (typed) res = typed_res;
    expected_results.push_back(res);
    items_sent++;
    case (cmd)
      CMD_INSERT: n_insert++;
      CMD_DELETE: n_delete++;
      CMD_SEARCH: n_search++;
      default:    n_clear++;
    endcase
    if (res.status == ST_FULL) n_full++;
    if (res.status == ST_DUPLICATE) n_dup++;
    if (res.status == ST_NOT_FOUND) n_miss++;
    if (int'(mirror_count) > peak_count) peak_count = int'(mirror_count);
  endtask

  // Hold the sender off until every result is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    table_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no command outstanding: tdata %h", m_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("success", want.success, m_tdata[0]);
        check_field("slot", want.slot, m_tdata[OUT_SLOT_LSB +: SLOT_W]);
        check_field("status", want.status, m_tdata[OUT_STAT_LSB +: 2]);
        check_field("entry_count", want.count, m_tdata[OUT_CNT_LSB +: CNT_W]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_results.size());
        $display("tb_sorted_linked_table_engine_top failed");
        $finish;
      end
    end
  end

  initial begin
    int target;
    int n;
    logic [31:0] k;
    rebuild_table();
    for (int i = 0; i < ENTRIES; i++) mirror_key[i] = '0;

    // Empty table, extremes, duplicates, free-chain reuse, clear
    add_row(CMD_SEARCH, 32'h0000_0000, 1, 0, 0, ST_NOT_FOUND, 0);
    add_row(CMD_DELETE, 32'h0000_0000, 1, 0, 0, ST_NOT_FOUND, 0);
    add_row(CMD_INSERT, 32'h7fff_ffff, 1, 1, 0, ST_OK, 1);
    add_row(CMD_INSERT, 32'h8000_0000, 1, 1, 1, ST_OK, 2);
    add_row(CMD_INSERT, 32'h7fff_ffff, 1, 0, 0, ST_DUPLICATE, 2);
    add_row(CMD_SEARCH, 32'h8000_0000, 1, 1, 1, ST_OK, 2);
    add_row(CMD_SEARCH, 32'h7fff_ffff, 1, 1, 0, ST_OK, 2);
    add_row(CMD_INSERT, 32'h0000_0000, 1, 1, 2, ST_OK, 3);
    add_row(CMD_INSERT, 32'hffff_ffff, 1, 1, 3, ST_OK, 4);
    add_row(CMD_INSERT, 32'h0000_0001, 1, 1, 4, ST_OK, 5);
    add_row(CMD_SEARCH, 32'h0000_0005, 1, 0, 0, ST_NOT_FOUND, 5);
    add_row(CMD_DELETE, 32'h8000_0000, 1, 1, 1, ST_OK, 4);
    add_row(CMD_INSERT, 32'h5555_5555, 0, 0, 0, ST_OK, 0);
    add_row(CMD_DELETE, 32'hffff_ffff, 1, 1, 3, ST_OK, 4);
    add_row(CMD_DELETE, 32'hffff_ffff, 1, 0, 0, ST_NOT_FOUND, 4);
    add_row(CMD_INSERT, 32'haaaa_aaaa, 0, 0, 0, ST_OK, 0);
    add_row(CMD_SEARCH, 32'h0000_0000, 0, 0, 0, ST_OK, 0);
    add_row(CMD_CLEAR,  32'hdead_beef, 1, 1, 0, ST_OK, 0);
    add_row(CMD_SEARCH, 32'h0000_0000, 1, 0, 0, ST_NOT_FOUND, 0);
    add_row(CMD_INSERT, 32'h1234_5678, 1, 1, 0, ST_OK, 1);
    add_row(CMD_DELETE, 32'h1234_5678, 1, 1, 0, ST_OK, 0);
    add_row(CMD_INSERT, 32'hffff_fffb, 1, 1, 0, ST_OK, 1);
    add_row(CMD_CLEAR,  32'h0000_0000, 1, 1, 0, ST_OK, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].typed,
                directed_rows[i].res);
    wait_drained();

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      calm = (items_sent >= target - RANDOM_ITEMS + 700) &&
             (items_sent < target - RANDOM_ITEMS + 950);
      case ($urandom_range(9))
        0, 1: begin
          // Fill to capacity, then push inserts and searches at a full table
          while (mirror_count < ENTRIES) begin
            k = ($urandom_range(3) == 0) ? choose_key() : $urandom;
            send_item(CMD_INSERT, k);
          end
          repeat (4) begin
            k = $urandom_range(1) ? pick_held_key() : $urandom;
            send_item($urandom_range(2) ? CMD_INSERT : CMD_SEARCH, k);
          end
        end
        2: begin
          // Drain, with the odd search and re-insert
          n = 0;
          while (mirror_count > 0 && n < 80) begin
            case ($urandom_range(5))
              0: send_item(CMD_SEARCH, choose_key());
              1: send_item(CMD_INSERT, choose_key());
              default: send_item(CMD_DELETE, pick_held_key());
            endcase
            n++;
          end
        end
        3: begin
          repeat (20) send_item(cmd_e_t'($urandom_range(3)), $urandom);
        end
        default: begin
          repeat (40) begin
            n = $urandom_range(99);
            if (n < 40)      send_item(CMD_INSERT, choose_key());
            else if (n < 65) send_item(CMD_DELETE, choose_key());
            else if (n < 97) send_item(CMD_SEARCH, choose_key());
            else             send_item(CMD_CLEAR, $urandom);
          end
        end
      endcase
      if ($urandom_range(3) == 0) wait_drained();
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands: %0d insert, %0d delete, %0d search, %0d clear.",
             items_sent, n_insert, n_delete, n_search, n_clear);
    $display("Rejects: %0d table full, %0d duplicate, %0d not found; peak fill %0d.",
             n_full, n_dup, n_miss, peak_count);
    if (errors == 0) begin
      $display("tb_sorted_linked_table_engine_top passed");
    end else begin
      $display("tb_sorted_linked_table_engine_top failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/slte_pkg.sv
src/slte_ram.sv
src/slte_ctrl.sv
src/slte_dp.sv
src/sorted_linked_table_engine_top.sv
src/slte_checker.sv
dv/tb_sorted_linked_table_engine_top.sv
